// ===== src/arrg_pkg.sv =====
// ----------------------------------------------------------------------------
// arrg_pkg
// Shared types and constants for the adaptive refresh rate governor.
// ----------------------------------------------------------------------------
package arrg_pkg;

  localparam int unsigned IvW   = 9;
  localparam int unsigned CostW = 16;
  localparam int unsigned CntW  = 4;
  localparam int unsigned CfgDW = 16;
  localparam int unsigned CfgIW = 3;

  localparam logic [IvW-1:0]  IV_FAST = 9'd80;
  localparam logic [IvW-1:0]  IV_LOW  = 9'd160;
  localparam logic [IvW-1:0]  IV_SLOW = 9'd333;
  localparam logic [CntW-1:0] CNT_MAX = 4'd15;

  localparam logic [CostW-1:0] RST_STEPDOWN_LAST = 16'd192;
  localparam logic [CostW-1:0] RST_STEPDOWN_AVG  = 16'd128;
  localparam logic [CostW-1:0] RST_SEVERE_LAST   = 16'd384;
  localparam logic [CostW-1:0] RST_SEVERE_AVG    = 16'd256;
  localparam logic [CntW-1:0]  RST_RECOVER       = 4'd3;

  typedef logic [CfgIW-1:0] cfg_idx_t;
  typedef logic [CfgDW-1:0] cfg_data_t;

  localparam cfg_idx_t REG_ACCELERATED     = 3'd0;
  localparam cfg_idx_t REG_BASE_INTERVAL   = 3'd1;
  localparam cfg_idx_t REG_STEPDOWN_LAST   = 3'd2;
  localparam cfg_idx_t REG_STEPDOWN_AVG    = 3'd3;
  localparam cfg_idx_t REG_SEVERE_LAST     = 3'd4;
  localparam cfg_idx_t REG_SEVERE_AVG      = 3'd5;
  localparam cfg_idx_t REG_RECOVER_REPORTS = 3'd6;

  typedef enum logic [1:0] {
    RSN_NONE      = 2'd0,
    RSN_SEVERE    = 2'd1,
    RSN_PRESSURE  = 2'd2,
    RSN_RECOVERED = 2'd3
  } reason_t;

  typedef struct packed {
    logic             accelerated;
    logic [IvW-1:0]   base_interval;
    logic [CostW-1:0] stepdown_last;
    logic [CostW-1:0] stepdown_avg;
    logic [CostW-1:0] severe_last;
    logic [CostW-1:0] severe_avg;
    logic [CntW-1:0]  recover_reports;
  } cfg_t;

  typedef struct packed {
    logic [CostW-1:0] work_last;
    logic [CostW-1:0] work_avg;
    logic [CostW-1:0] rebuild_last;
    logic [CostW-1:0] rebuild_avg;
    logic             rebuild_flag;
  } report_t;

  typedef struct packed {
    logic [IvW-1:0] refresh_iv;
    logic           interval_changed;
    reason_t        reason_code;
  } result_t;

  typedef struct packed {
    logic [IvW-1:0]  cur_interval;
    logic [CntW-1:0] fast_cnt;
  } gov_state_t;

endpackage

// ===== src/arrg_if.sv =====
// ----------------------------------------------------------------------------
// arrg_report_if / arrg_result_if
// Valid/ready channels for cost reports and governor results.
// ----------------------------------------------------------------------------
interface arrg_report_if;
  logic        valid;
  logic        ready;
  logic [15:0] work_last;
  logic [15:0] work_avg;
  logic [15:0] rebuild_last;
  logic [15:0] rebuild_avg;
  logic        rebuild_flag;

  modport source (output valid, work_last, work_avg, rebuild_last, rebuild_avg,
                  rebuild_flag, input ready);
  modport sink   (input valid, work_last, work_avg, rebuild_last, rebuild_avg,
                  rebuild_flag, output ready);
endinterface

interface arrg_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] refresh_iv;
  logic       interval_changed;
  logic [1:0] reason_code;

  modport source (output valid, refresh_iv, interval_changed, reason_code,
                  input ready);
  modport sink   (input valid, refresh_iv, interval_changed, reason_code,
                  output ready);
endinterface

// ===== src/arrg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// arrg_cfg_regs
// Configuration register file; saturates the base interval on write.
// ----------------------------------------------------------------------------
module arrg_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  arrg_pkg::cfg_idx_t  cfg_idx,
  input  arrg_pkg::cfg_data_t cfg_wdata,
  output arrg_pkg::cfg_t      cfg,
  output logic                base_load
);
  import arrg_pkg::*;

  cfg_t           cfg_r;
  logic [IvW-1:0] base_raw;
  logic [IvW-1:0] base_sat;

  assign base_raw = cfg_wdata[IvW-1:0];

  always_comb begin
    if (base_raw < IV_FAST) begin
      base_sat = IV_FAST;
    end else if (base_raw > IV_SLOW) begin
      base_sat = IV_SLOW;
    end else begin
      base_sat = base_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accelerated     <= 1'b1;
      cfg_r.base_interval   <= IV_FAST;
      cfg_r.stepdown_last   <= RST_STEPDOWN_LAST;
      cfg_r.stepdown_avg    <= RST_STEPDOWN_AVG;
      cfg_r.severe_last     <= RST_SEVERE_LAST;
      cfg_r.severe_avg      <= RST_SEVERE_AVG;
      cfg_r.recover_reports <= RST_RECOVER;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ACCELERATED:     cfg_r.accelerated     <= cfg_wdata[0];
        REG_BASE_INTERVAL:   cfg_r.base_interval   <= base_sat;
        REG_STEPDOWN_LAST:   cfg_r.stepdown_last   <= cfg_wdata;
        REG_STEPDOWN_AVG:    cfg_r.stepdown_avg    <= cfg_wdata;
        REG_SEVERE_LAST:     cfg_r.severe_last     <= cfg_wdata;
        REG_SEVERE_AVG:      cfg_r.severe_avg      <= cfg_wdata;
        REG_RECOVER_REPORTS: cfg_r.recover_reports <= cfg_wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign base_load = cfg_we && (cfg_idx == REG_BASE_INTERVAL);

endmodule

// ===== src/arrg_decide.sv =====
// ----------------------------------------------------------------------------
// arrg_decide
// Steady-cost extraction, threshold classification and interval stepping.
// ----------------------------------------------------------------------------
module arrg_decide (
  input  arrg_pkg::report_t    rpt,
  input  arrg_pkg::cfg_t       cfg,
  input  arrg_pkg::gov_state_t st,
  output arrg_pkg::gov_state_t st_nxt,
  output arrg_pkg::result_t    res
);
  import arrg_pkg::*;

  logic [CostW-1:0] steady_last;
  logic [CostW-1:0] steady_avg;
  logic [IvW-1:0]   low_iv;
  logic [IvW-1:0]   target;
  reason_t          why;
  logic [CntW-1:0]  cnt_inc;
  logic [IvW-1:0]   recov_iv;
  logic             active;

  assign active = cfg.accelerated && (cfg.base_interval < IV_SLOW);
  assign low_iv = (cfg.base_interval > IV_LOW) ? cfg.base_interval : IV_LOW;

  always_comb begin
    steady_last = rpt.work_last;
    steady_avg  = rpt.work_avg;
    if (rpt.rebuild_flag) begin
      steady_last = (rpt.work_last > rpt.rebuild_last) ?
                    rpt.work_last - rpt.rebuild_last : '0;
      steady_avg  = (rpt.work_avg > rpt.rebuild_avg) ?
                    rpt.work_avg - rpt.rebuild_avg : '0;
    end
  end

  always_comb begin
    target = cfg.base_interval;
    why    = RSN_NONE;
    if (steady_last >= cfg.severe_last || steady_avg >= cfg.severe_avg) begin
      target = IV_SLOW;
      why    = RSN_SEVERE;
    end else if (steady_last >= cfg.stepdown_last || steady_avg >= cfg.stepdown_avg) begin
      target = low_iv;
      why    = RSN_PRESSURE;
    end
  end

  assign cnt_inc  = (st.fast_cnt < CNT_MAX) ? st.fast_cnt + 1'b1 : st.fast_cnt;
  assign recov_iv = (st.cur_interval >= IV_SLOW) ? low_iv : cfg.base_interval;

  always_comb begin
    st_nxt               = st;
    res.interval_changed = 1'b0;
    res.reason_code      = RSN_NONE;
    if (active) begin
      if (target > st.cur_interval) begin
        st_nxt.fast_cnt      = '0;
        st_nxt.cur_interval  = target;
        res.interval_changed = 1'b1;
        res.reason_code      = why;
      end else if (target == cfg.base_interval && st.cur_interval > cfg.base_interval) begin
        st_nxt.fast_cnt = cnt_inc;
        if (cnt_inc >= cfg.recover_reports) begin
          st_nxt.fast_cnt = '0;
          if (recov_iv != st.cur_interval) begin
            st_nxt.cur_interval  = recov_iv;
            res.interval_changed = 1'b1;
            res.reason_code      = RSN_RECOVERED;
          end
        end
      end else begin
        st_nxt.fast_cnt = '0;
      end
    end
    res.refresh_iv = st_nxt.cur_interval;
  end

endmodule

// ===== src/adaptive_refresh_rate_governor.sv =====
// ----------------------------------------------------------------------------
// adaptive_refresh_rate_governor
// Picks the refresh interval from a stream of cost reports.
// ----------------------------------------------------------------------------
// One cost report can be accepted every cycle while results are taken,
// and each gives exactly one result. The report lands in an input
// register; the decision logic, run against the governor state, then
// writes the result register and the new state together once the output
// register is free or its result is taken. While a result waits at the
// output, one more report is held in the input register and the input
// then stalls until the result is taken. Configuration writes are applied
// at once; a base interval write also reloads the current interval.
// ----------------------------------------------------------------------------
module adaptive_refresh_rate_governor (
  input  logic                clk,
  input  logic                rst_n,
  arrg_report_if.sink         in_rpt,
  arrg_result_if.source       out_res,
  input  logic                cfg_we,
  input  arrg_pkg::cfg_idx_t  cfg_idx,
  input  arrg_pkg::cfg_data_t cfg_wdata
);
  import arrg_pkg::*;

  cfg_t       cfg;
  logic       base_load;
  report_t    rpt_r;
  logic       rpt_vld_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       res_vld_r;
  gov_state_t st_r;
  gov_state_t st_nxt;
  logic       advance;
  logic       in_take;

  assign advance      = !res_vld_r || out_res.ready;
  assign in_rpt.ready = rst_n && (!rpt_vld_r || advance);
  assign in_take      = in_rpt.valid && in_rpt.ready;

  arrg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .base_load (base_load)
  );

  arrg_decide u_decide (
    .rpt    (rpt_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      rpt_r.work_last    <= in_rpt.work_last;
      rpt_r.work_avg     <= in_rpt.work_avg;
      rpt_r.rebuild_last <= in_rpt.rebuild_last;
      rpt_r.rebuild_avg  <= in_rpt.rebuild_avg;
      rpt_r.rebuild_flag <= in_rpt.rebuild_flag;
    end
    if (rpt_vld_r && advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      st_r.cur_interval <= IV_FAST;
      st_r.fast_cnt     <= '0;
    end else begin
      if (in_rpt.ready) begin
        rpt_vld_r <= in_rpt.valid;
      end
      if (advance) begin
        res_vld_r <= rpt_vld_r;
      end
      if (base_load) begin
        st_r.cur_interval <= cfg_wdata[IvW-1:0] < IV_FAST ? IV_FAST :
                             cfg_wdata[IvW-1:0] > IV_SLOW ? IV_SLOW :
                             cfg_wdata[IvW-1:0];
      end else if (rpt_vld_r && advance) begin
        st_r <= st_nxt;
      end
    end
  end

  assign out_res.valid            = res_vld_r;
  assign out_res.refresh_iv       = res_r.refresh_iv;
  assign out_res.interval_changed = res_r.interval_changed;
  assign out_res.reason_code      = res_r.reason_code;

endmodule

// ===== src/arrg_checker.sv =====
// ----------------------------------------------------------------------------
// arrg_checker
// Port-level checks for the adaptive refresh rate governor.
// ----------------------------------------------------------------------------
module arrg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] refresh_iv,
  input logic       interval_changed,
  input logic [1:0] reason_code
);
  import arrg_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(refresh_iv) &&
    $stable(interval_changed) && $stable(reason_code))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (interval_changed == (reason_code != RSN_NONE)))
    else $error("reason code disagrees with change flag");

  a_severe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reason_code == RSN_SEVERE |-> refresh_iv == IV_SLOW)
    else $error("severe result not at slowest interval");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> refresh_iv >= IV_FAST && refresh_iv <= IV_SLOW)
    else $error("interval out of range");

endmodule

bind adaptive_refresh_rate_governor arrg_checker u_arrg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_rpt.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .refresh_iv       (out_res.refresh_iv),
  .interval_changed (out_res.interval_changed),
  .reason_code      (out_res.reason_code)
);
